// ===== rtl/core/lmes_pkg.sv =====
`timescale 1ns / 1ps
package lmes_pkg;

  // input item kinds
  localparam logic [2:0] KIND_TEXT = 3'd0;
  localparam logic [2:0] KIND_END  = 3'd1;
  localparam logic [2:0] KIND_WKEY = 3'd2;
  localparam logic [2:0] KIND_WVAL = 3'd3;
  localparam logic [2:0] KIND_WLEN = 3'd4;

  // classified operations handed to the back end
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_TEXT   = 3'd1;
  localparam logic [2:0] OP_DOLLAR = 3'd2;
  localparam logic [2:0] OP_END    = 3'd3;
  localparam logic [2:0] OP_WKEY   = 3'd4;
  localparam logic [2:0] OP_WVAL   = 3'd5;
  localparam logic [2:0] OP_WLEN   = 3'd6;

  // configuration register indexes
  localparam logic [7:0] REG_ENTRY_COUNT  = 8'd0;
  localparam logic [7:0] REG_DROP_DOLLARS = 8'd1;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] DOLLAR = 8'h24;

  // flushed bytes allowed before the status word
  localparam logic [3:0] MAX_FLUSH = 4'd15;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [3:0] byte_pos;
    logic [3:0] key_length;
    logic [3:0] value_length;
  } item_t;

endpackage

// ===== rtl/core/lmes_ram.sv =====
`timescale 1ns / 1ps
module lmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lmes_front.sv =====
`timescale 1ns / 1ps
module lmes_front import lmes_pkg::*; #(
  parameter int WINDOW_BYTES = 15,
  parameter int DICT_ENTRIES = 256,
  parameter int VALUE_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        drop_dollars,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  entry_index,
  input  logic [3:0]  byte_pos,
  input  logic [3:0]  key_length,
  input  logic [3:0]  value_length,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       fifo [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        idx_ok;
  item_t       cls;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];
  assign idx_ok   = int'(entry_index) < DICT_ENTRIES;

  // classify
  always_comb begin
    cls.data_byte    = data_byte;
    cls.entry_index  = entry_index;
    cls.byte_pos     = byte_pos;
    cls.key_length   = key_length;
    cls.value_length = value_length;
    cls.op           = OP_NOP;
    case (kind)
      KIND_TEXT: cls.op = (drop_dollars && data_byte == DOLLAR) ? OP_DOLLAR : OP_TEXT;
      KIND_END:  cls.op = OP_END;
      KIND_WKEY: if (idx_ok && int'(byte_pos) < WINDOW_BYTES) cls.op = OP_WKEY;
      KIND_WVAL: if (idx_ok && int'(byte_pos) < VALUE_BYTES) cls.op = OP_WVAL;
      KIND_WLEN: if (idx_ok) cls.op = OP_WLEN;
      default:   cls.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== rtl/core/lmes_back.sv =====
`timescale 1ns / 1ps
module lmes_back import lmes_pkg::*; #(
  parameter int WINDOW_BYTES = 15,
  parameter int DICT_ENTRIES = 256,
  parameter int VALUE_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [8:0]  entry_count,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_status,
  output logic        frame_ok,
  output logic        last
);

  localparam int AW   = DICT_ENTRIES > 1 ? $clog2(DICT_ENTRIES) : 1;
  localparam int NW   = $clog2(DICT_ENTRIES + 1);
  localparam int FW   = $clog2(WINDOW_BYTES + 1);
  localparam int IW   = $clog2(WINDOW_BYTES);
  localparam int EW   = $clog2(VALUE_BYTES + 1);
  localparam int CMPN = VALUE_BYTES < WINDOW_BYTES ? VALUE_BYTES : WINDOW_BYTES;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HEAD   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_STATUS = 3'd5;

  logic [2:0]    state;
  logic [7:0]    win [WINDOW_BYTES];
  logic [7:0]    win_sh [WINDOW_BYTES];
  logic [FW-1:0] fill;
  logic [7:0]    first_raw;
  logic [7:0]    prev_raw;
  logic [1:0]    raw_count;
  logic          flush;
  logic [3:0]    flush_cnt;
  logic [NW-1:0] scan_cnt;
  logic [NW-1:0] active;
  logic          pend;
  logic [15:0]   found;
  logic [FW-1:0] best_len;
  logic [EW-1:0] best_vlen;
  logic [7:0]    val_sh [VALUE_BYTES];
  logic [EW-1:0] emit_n;
  logic [EW-1:0] emit_i;
  logic          src_val;
  logic [FW-1:0] drop_n;
  logic          slot_free;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    key_q [WINDOW_BYTES];
  logic [7:0]    val_q [VALUE_BYTES];
  logic [7:0]    len_q;
  logic [3:0]    klen_q;
  logic [3:0]    vlen_q;
  logic          key_hit;
  logic          same_key;
  logic [3:0]    vlen_clamp;
  logic [FW-1:0] fill_left;

  assign slot_free = !out_valid || out_ready;
  assign active    = (int'(entry_count) > DICT_ENTRIES) ? NW'(DICT_ENTRIES) : NW'(entry_count);
  assign raddr     = scan_cnt[AW-1:0];
  assign waddr     = AW'(q_item.entry_index);
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign klen_q    = len_q[7:4];
  assign vlen_q    = len_q[3:0];
  assign vlen_clamp = (int'(q_item.value_length) > VALUE_BYTES) ?
                      4'(VALUE_BYTES) : q_item.value_length;
  assign fill_left = fill - drop_n;

  // dictionary: one byte lane per key and value position
  for (genvar g = 0; g < WINDOW_BYTES; g++) begin : g_key
    lmes_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_key (
      .clk   (clk),
      .we    (q_pop && q_item.op == OP_WKEY && int'(q_item.byte_pos) == g),
      .waddr (waddr),
      .wdata (q_item.data_byte),
      .raddr (raddr),
      .rdata (key_q[g])
    );
  end

  for (genvar g = 0; g < VALUE_BYTES; g++) begin : g_val
    lmes_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_val (
      .clk   (clk),
      .we    (q_pop && q_item.op == OP_WVAL && int'(q_item.byte_pos) == g),
      .waddr (waddr),
      .wdata (q_item.data_byte),
      .raddr (raddr),
      .rdata (val_q[g])
    );
  end

  lmes_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_len (
    .clk   (clk),
    .we    (q_pop && q_item.op == OP_WLEN),
    .waddr (waddr),
    .wdata ({q_item.key_length, vlen_clamp}),
    .raddr (raddr),
    .rdata (len_q)
  );

  // compare the entry read last cycle against the window
  always_comb begin
    key_hit  = (klen_q != 4'd0) && (int'(klen_q) <= int'(fill));
    same_key = (vlen_q == klen_q);
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (i < int'(klen_q) && key_q[i] != win[i]) key_hit = 1'b0;
    end
    for (int i = 0; i < CMPN; i++) begin
      if (i < int'(vlen_q) && key_q[i] != val_q[i]) same_key = 1'b0;
    end
  end

  // window after dropping drop_n head bytes
  always_comb begin
    logic [IW:0] s;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      s = (IW + 1)'(i) + (IW + 1)'(drop_n);
      win_sh[i] = (int'(s) < WINDOW_BYTES) ? win[s[IW-1:0]] : win[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      first_raw <= 8'h00;
      prev_raw  <= 8'h00;
      raw_count <= 2'd0;
      out_valid <= 1'b0;
      flush     <= 1'b0;
      flush_cnt <= 4'd0;
      pend      <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_TEXT || q_item.op == OP_DOLLAR) begin
              if (raw_count == 2'd0) first_raw <= q_item.data_byte;
              prev_raw <= q_item.data_byte;
              if (raw_count != 2'd3) raw_count <= raw_count + 2'd1;
            end
            if (q_item.op == OP_TEXT) begin
              if (int'(fill) < WINDOW_BYTES) begin
                win[fill[IW-1:0]] <= q_item.data_byte;
                fill <= fill + FW'(1);
                if (int'(fill) + 1 >= WINDOW_BYTES) begin
                  flush <= 1'b0;
                  state <= ST_HEAD;
                end
              end
            end else if (q_item.op == OP_END) begin
              flush     <= 1'b1;
              flush_cnt <= 4'd0;
              state     <= (fill != '0) ? ST_HEAD : ST_STATUS;
            end
          end
        end
        ST_HEAD: begin
          if (win[0] == BSLASH) begin
            scan_cnt <= '0;
            pend     <= 1'b0;
            found    <= '0;
            best_len <= '0;
            state    <= ST_SCAN;
          end else begin
            emit_n  <= EW'(1);
            emit_i  <= '0;
            src_val <= 1'b0;
            drop_n  <= FW'(1);
            state   <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (scan_cnt < active) begin
            scan_cnt <= scan_cnt + NW'(1);
            pend     <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) state <= ST_DECIDE;
          end
          // first matching entry of each key length decides that length
          if (pend && key_hit && !found[klen_q]) begin
            found[klen_q] <= 1'b1;
            if (!same_key && int'(klen_q) > int'(best_len)) begin
              best_len  <= FW'(klen_q);
              best_vlen <= EW'(vlen_q);
              for (int i = 0; i < VALUE_BYTES; i++) val_sh[i] <= val_q[i];
            end
          end
        end
        ST_DECIDE: begin
          emit_i <= '0;
          if (best_len != '0) begin
            emit_n  <= best_vlen;
            src_val <= 1'b1;
            drop_n  <= best_len;
          end else begin
            emit_n  <= EW'(1);
            src_val <= 1'b0;
            drop_n  <= FW'(1);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_i != emit_n) begin
            if (slot_free) begin
              if (!flush || flush_cnt != MAX_FLUSH) begin
                out_valid <= 1'b1;
                out_byte  <= src_val ? val_sh[0] : win[0];
                is_status <= 1'b0;
                frame_ok  <= 1'b0;
                last      <= !flush && (int'(emit_i) + 1 == int'(emit_n));
                if (flush) flush_cnt <= flush_cnt + 4'd1;
              end
              for (int i = 0; i < VALUE_BYTES - 1; i++) val_sh[i] <= val_sh[i + 1];
              emit_i <= emit_i + EW'(1);
            end
          end else begin
            for (int i = 0; i < WINDOW_BYTES; i++) win[i] <= win_sh[i];
            fill <= fill_left;
            if (flush) state <= (fill_left != '0) ? ST_HEAD : ST_STATUS;
            else       state <= ST_IDLE;
          end
        end
        ST_STATUS: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_byte  <= 8'h00;
            is_status <= 1'b1;
            frame_ok  <= (raw_count == 2'd3) && (first_raw == DOLLAR) && (prev_raw == DOLLAR);
            last      <= 1'b1;
            fill      <= '0;
            first_raw <= 8'h00;
            prev_raw  <= 8'h00;
            raw_count <= 2'd0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/longest_match_escape_substituter_core.sv =====
`timescale 1ns / 1ps
// longest-match escape substituter
// input stream (s_axis_*): kind in tuser, text byte or dictionary write in tdata.
//   text bytes are rewritten; kinds 2 to 4 load the dictionary byte by byte.
// output stream (m_axis_*): one text byte per word, then a status word after
//   end of text with is_status and frame_ok in tuser; tlast marks the final
//   word caused by one input word.
// cfg port: index 0 entry_count, index 1 drop_dollars; always ready, write only
//   while the block is idle.
// sequence: each word is taken off the queue in the idle state; a dictionary write or a
//   text byte that only fills the window needs nothing more. a plain head byte
//   passes through the head and emit states. a backslash head walks every active
//   entry (entry_count, capped at DICT_ENTRIES), one per cycle, then decides and
//   emits its bytes. end of text repeats that per flushed head byte, then
//   gives the status word.
// a two-word queue sits between the input side and the sequencer, and the
//   output register lets the sequencer finish a word while the receiver waits.
// a stalled receiver (m_axis_tready low) holds the output word; the sequencer
//   then stops and the queue fills, and s_axis_tready drops.
// reset: window empty, frame tracking cleared, entry_count 0, drop_dollars 1.
//   the dictionary memories are not cleared and must be loaded before use.
module longest_match_escape_substituter_core import lmes_pkg::*; #(
  parameter int WINDOW_BYTES = 15,
  parameter int DICT_ENTRIES = 256,
  parameter int VALUE_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte, entry_index, byte_pos, key_length, value_length
  input  logic [2:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic [1:0]  m_axis_tuser,  // is_status, frame_ok
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [8:0] entry_count;
  logic       drop_dollars;
  logic       q_valid;
  logic       q_pop;
  item_t      q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= 9'd0;
      drop_dollars <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENTRY_COUNT:  entry_count  <= cfg_data[8:0];
        REG_DROP_DOLLARS: drop_dollars <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: accept and classify input words into the queue
  lmes_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .DICT_ENTRIES (DICT_ENTRIES),
    .VALUE_BYTES  (VALUE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .drop_dollars (drop_dollars),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .kind         (s_axis_tuser),
    .data_byte    (s_axis_tdata[7:0]),
    .entry_index  (s_axis_tdata[15:8]),
    .byte_pos     (s_axis_tdata[19:16]),
    .key_length   (s_axis_tdata[23:20]),
    .value_length (s_axis_tdata[27:24]),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: window, dictionary search and output sequencing
  lmes_back #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .DICT_ENTRIES (DICT_ENTRIES),
    .VALUE_BYTES  (VALUE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .is_status   (m_axis_tuser[0]),
    .frame_ok    (m_axis_tuser[1]),
    .last        (m_axis_tlast)
  );

endmodule
